>>> rtl/ntc_thermistor_temperature_macros.svh
// Assertion macros shared by the thermistor thermometer RTL.
`ifndef NTC_THERMISTOR_TEMPERATURE_MACROS_SVH
`define NTC_THERMISTOR_TEMPERATURE_MACROS_SVH

`ifndef SYNTHESIS
`define NTC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ntc assertion failed");
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntc assertion failed");
`else
`define NTC_ASSERT(lbl, prop)
`define NTC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/ntc_pkg.sv
// Types, constants and the logarithm table of the thermistor thermometer.
package ntc_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int LOG_DEPTH   = 256;

    localparam int TOT_W  = 20;
    localparam int CNT_W  = 9;
    localparam int V_W    = 17;
    localparam int RQ_W   = 45;
    localparam int LOG_W  = 37;
    localparam int DIFF_W = 36;
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 48;
    localparam int LT_W   = 31;

    localparam logic [23:0] LN2_Q24      = 24'd11629080;
    localparam int          KELVIN_CENTI = 27315;
    localparam int          LOW_CENTI    = -6000;
    localparam int          HIGH_CENTI   = 8000;

    // configuration register indexes
    localparam logic [2:0] REG_SUPPLY  = 3'd0;
    localparam logic [2:0] REG_FIXED_R = 3'd1;
    localparam logic [2:0] REG_R0      = 3'd2;
    localparam logic [2:0] REG_BETA    = 3'd3;
    localparam logic [2:0] REG_T0      = 3'd4;
    localparam logic [2:0] REG_COUNT   = 3'd5;
    localparam logic [2:0] REG_CAL_EN  = 3'd6;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FAIL    = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    // datapath operations
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_ACCEPT  = 5'd1;
    localparam logic [4:0] OP_VDIV    = 5'd2;
    localparam logic [4:0] OP_STV     = 5'd3;
    localparam logic [4:0] OP_RDIV    = 5'd4;
    localparam logic [4:0] OP_STRQ    = 5'd5;
    localparam logic [4:0] OP_NLOAD   = 5'd6;
    localparam logic [4:0] OP_LOOK    = 5'd7;
    localparam logic [4:0] OP_STLOG   = 5'd8;
    localparam logic [4:0] OP_DIFF    = 5'd9;
    localparam logic [4:0] OP_SAVE    = 5'd10;
    localparam logic [4:0] OP_L24     = 5'd11;
    localparam logic [4:0] OP_NUM     = 5'd12;
    localparam logic [4:0] OP_B100    = 5'd13;
    localparam logic [4:0] OP_DEN     = 5'd14;
    localparam logic [4:0] OP_TDIV    = 5'd15;
    localparam logic [4:0] OP_STT     = 5'd16;
    localparam logic [4:0] OP_OUT     = 5'd17;
    localparam logic [4:0] OP_OUTFAIL = 5'd18;

    // multiplier operand selects
    localparam logic [3:0] MUL_HOLD  = 4'd0;
    localparam logic [3:0] MUL_RAW   = 4'd1;
    localparam logic [3:0] MUL_RV    = 4'd2;
    localparam logic [3:0] MUL_INT   = 4'd3;
    localparam logic [3:0] MUL_D0    = 4'd4;
    localparam logic [3:0] MUL_D1    = 4'd5;
    localparam logic [3:0] MUL_TB    = 4'd6;
    localparam logic [3:0] MUL_TB100 = 4'd7;
    localparam logic [3:0] MUL_B100  = 4'd8;
    localparam logic [3:0] MUL_TL    = 4'd9;

    typedef struct packed {
        logic [4:0] op;
        logic [3:0] mul_sel;
        logic       second;
    } cmd_t;

    typedef struct packed {
        logic in_fail;
        logic closing;
        logic div_done;
        logic norm_done;
        logic r_valid;
        logic t_ok;
        logic den_zero;
    } stat_t;

    typedef logic [LT_W-1:0] log_tab_t [0:LOG_DEPTH];

    // log2 of a Q30 mantissa in [1,2] by repeated squaring
    function automatic logic [LT_W-1:0] log2_mant(logic [63:0] m_in);
        logic [63:0]     m;
        logic [LT_W-1:0] acc;
        m   = m_in;
        acc = '0;
        if (m >= (64'd2 << 30))
        begin
            acc = LT_W'(64'd1 << 30);
        end
        else
        begin
            for (int i = 29; i >= 0; i--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    acc[i] = 1'b1;
                end
            end
        end
        return acc;
    endfunction

    function automatic log_tab_t build_log_table();
        log_tab_t t;
        for (int k = 0; k <= LOG_DEPTH; k++)
        begin
            t[k] = log2_mant((64'(LOG_DEPTH + k) << 30) / 64'(LOG_DEPTH));
        end
        return t;
    endfunction

    localparam log_tab_t LOG_TABLE = build_log_table();

endpackage

>>> rtl/ntc_div.sv
// Restoring divider, one quotient bit per cycle.
module ntc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ntc_pkg::DVD_W-1:0]  dividend,
    input  logic [ntc_pkg::DVS_W-1:0]  divisor,
    output logic                       busy,
    output logic                       done,
    output logic [ntc_pkg::DVD_W-1:0]  quotient
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [5:0]                cnt_reg;
    logic [ntc_pkg::DVD_W-1:0] dvd_reg;
    logic [ntc_pkg::DVS_W:0]   rem_reg;
    logic [ntc_pkg::DVS_W-1:0] dvs_reg;
    logic [ntc_pkg::DVS_W:0]   trial;
    logic [ntc_pkg::DVS_W:0]   rem_next;
    logic                      fits;

    always_comb
    begin
        trial    = {rem_reg[ntc_pkg::DVS_W-1:0], dvd_reg[ntc_pkg::DVD_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? (trial - {1'b0, dvs_reg}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(ntc_pkg::DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[ntc_pkg::DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

>>> rtl/ntc_dp.sv
// Datapath: accumulators, configuration, shared multiplier, normaliser and result registers.
`include "ntc_thermistor_temperature_macros.svh"

module ntc_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  ntc_pkg::cmd_t       cmd,
    output ntc_pkg::stat_t      st,
    input  logic [11:0]         raw_code,
    input  logic [11:0]         cal_mv,
    input  logic                cal_ok,
    input  logic                read_ok,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [19:0]         cfg_data,
    output logic [15:0]         voltage_q4_mv,
    output logic [23:0]         rtherm_ohm,
    output logic signed [15:0]  temperature_centi_c,
    output logic                in_range,
    output logic [1:0]          status
);

    // configuration
    logic [12:0]        supply_reg;
    logic [19:0]        fixed_r_reg;
    logic [19:0]        r0_reg;
    logic [13:0]        beta_reg;
    logic [14:0]        t0_reg;
    logic [8:0]         count_reg;
    logic               cal_active_reg;

    // batch
    logic [ntc_pkg::CNT_W-1:0] idx_reg;
    logic [ntc_pkg::TOT_W-1:0] raw_tot_reg;
    logic [ntc_pkg::TOT_W-1:0] cal_tot_reg;

    // working registers
    logic [63:0]                prod_reg;
    logic [ntc_pkg::V_W-1:0]    v_reg;
    logic                       r_valid_reg;
    logic                       t_valid_reg;
    logic [ntc_pkg::RQ_W-1:0]   rq_reg;
    logic [ntc_pkg::RQ_W-1:0]   norm_x_reg;
    logic [5:0]                 norm_e_reg;
    logic [ntc_pkg::LT_W-1:0]   lo_reg;
    logic [ntc_pkg::LT_W-1:0]   dl_reg;
    logic [23:0]                frac_reg;
    logic [5:0]                 e_reg;
    logic [ntc_pkg::LOG_W-1:0]  logr_reg;
    logic [ntc_pkg::LOG_W-1:0]  log0_reg;
    logic [ntc_pkg::DIFF_W-1:0] diff_mag_reg;
    logic                       diff_neg_reg;
    logic [41:0]                save_reg;
    logic [30:0]                l24_reg;
    logic [61:0]                num_reg;
    logic [20:0]                b100_reg;
    logic [ntc_pkg::DVS_W-1:0]  den_mag_reg;
    logic                       den_neg_reg;
    logic                       den_zero_reg;
    logic [16:0]                q_reg;

    // combinational
    logic [8:0]                 limit;
    logic [31:0]                mul_a;
    logic [31:0]                mul_b;
    logic [20:0]                fs;
    logic [16:0]                supply_q4;
    logic [16:0]                t0c;
    logic                       div_start;
    logic [ntc_pkg::DVD_W-1:0]  div_dvd;
    logic [ntc_pkg::DVS_W-1:0]  div_dvs;
    logic                       div_busy;
    logic                       div_done;
    logic [ntc_pkg::DVD_W-1:0]  div_q;
    logic [ntc_pkg::RQ_W-1:0]   norm_src;
    logic [7:0]                 tab_idx;
    logic [ntc_pkg::LOG_W-1:0]  log_val;
    logic signed [38:0]         diff_s;
    logic [60:0]                l24_sum;
    logic [ntc_pkg::DVS_W-1:0]  b_sh;
    logic [ntc_pkg::DVS_W-1:0]  p_tl;
    logic [ntc_pkg::RQ_W:0]     r_round;
    logic [23:0]                r_out;
    logic signed [18:0]         temp_full;
    logic signed [15:0]         temp_out;
    logic                       inr;

    always_comb
    begin
        if (count_reg == 9'd0)
        begin
            limit = 9'd1;
        end
        else if (count_reg > 9'(ntc_pkg::MAX_SAMPLES))
        begin
            limit = 9'(ntc_pkg::MAX_SAMPLES);
        end
        else
        begin
            limit = count_reg;
        end
        fs        = {idx_reg, 12'd0} - {12'd0, idx_reg};
        supply_q4 = {supply_reg, 4'd0};
        t0c       = 17'(18'($signed(t0_reg)) + 18'(ntc_pkg::KELVIN_CENTI));
        norm_src  = cmd.second ? {25'd0, r0_reg} : rq_reg;
        tab_idx   = norm_x_reg[ntc_pkg::RQ_W-2 -: 8];
    end

    assign st.in_fail   = !read_ok;
    assign st.closing   = read_ok && ({1'b0, idx_reg} + 10'd1 >= {1'b0, limit});
    assign st.div_done  = div_done;
    assign st.norm_done = norm_x_reg[ntc_pkg::RQ_W-1];
    assign st.r_valid   = r_valid_reg;
    assign st.t_ok      = (rq_reg != '0) && (r0_reg != '0) && (beta_reg != '0);
    assign st.den_zero  = den_zero_reg;

    // shared multiplier operand selection
    always_comb
    begin
        case (cmd.mul_sel)
            ntc_pkg::MUL_RAW:
            begin
                mul_a = 32'(raw_tot_reg);
                mul_b = 32'(supply_reg);
            end
            ntc_pkg::MUL_RV:
            begin
                mul_a = 32'(fixed_r_reg);
                mul_b = 32'(v_reg);
            end
            ntc_pkg::MUL_INT:
            begin
                mul_a = 32'(dl_reg);
                mul_b = 32'(frac_reg);
            end
            ntc_pkg::MUL_D0:
            begin
                mul_a = 32'(diff_mag_reg[17:0]);
                mul_b = 32'(ntc_pkg::LN2_Q24);
            end
            ntc_pkg::MUL_D1:
            begin
                mul_a = 32'(diff_mag_reg[35:18]);
                mul_b = 32'(ntc_pkg::LN2_Q24);
            end
            ntc_pkg::MUL_TB:
            begin
                mul_a = 32'(t0c);
                mul_b = 32'(beta_reg);
            end
            ntc_pkg::MUL_TB100:
            begin
                mul_a = prod_reg[31:0];
                mul_b = 32'd100;
            end
            ntc_pkg::MUL_B100:
            begin
                mul_a = 32'(beta_reg);
                mul_b = 32'd100;
            end
            ntc_pkg::MUL_TL:
            begin
                mul_a = 32'(t0c);
                mul_b = 32'(l24_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // divider operand selection
    always_comb
    begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = '0;
        case (cmd.op)
            ntc_pkg::OP_VDIV:
            begin
                div_start = 1'b1;
                if (cal_active_reg)
                begin
                    div_dvd = 64'({cal_tot_reg, 4'd0}) + 64'(idx_reg >> 1);
                    div_dvs = 48'(idx_reg);
                end
                else
                begin
                    div_dvd = 64'({prod_reg[32:0], 4'd0}) + 64'(fs >> 1);
                    div_dvs = 48'(fs);
                end
            end
            ntc_pkg::OP_RDIV:
            begin
                div_start = 1'b1;
                div_dvd   = 64'({prod_reg[36:0], 8'd0});
                div_dvs   = 48'(supply_q4 - v_reg);
            end
            ntc_pkg::OP_TDIV:
            begin
                div_start = 1'b1;
                div_dvd   = 64'(num_reg) + 64'(den_mag_reg >> 1);
                div_dvs   = den_mag_reg;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    ntc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        log_val = {1'b0, e_reg, 30'd0} + ntc_pkg::LOG_W'(lo_reg) + ntc_pkg::LOG_W'(prod_reg[47:24]);
        diff_s  = $signed({2'b00, logr_reg}) - $signed({2'b00, log0_reg})
                  - $signed(39'(64'd8 << 30));
        l24_sum = {1'b0, prod_reg[41:0], 18'd0} + 61'(save_reg);
        b_sh    = 48'({b100_reg, 24'd0});
        p_tl    = prod_reg[ntc_pkg::DVS_W-1:0];
    end

    // result formatting
    always_comb
    begin
        r_round = {1'b0, rq_reg} + 46'd128;
        if (!r_valid_reg)
        begin
            r_out = '0;
        end
        else if (r_round[ntc_pkg::RQ_W:32] != '0)
        begin
            r_out = 24'hFFFFFF;
        end
        else
        begin
            r_out = r_round[31:8];
        end
        if (den_neg_reg)
        begin
            temp_full = -$signed({2'b00, q_reg}) - 19'sd27315;
        end
        else
        begin
            temp_full = $signed({2'b00, q_reg}) - 19'sd27315;
        end
        inr = t_valid_reg && (temp_full > 19'(ntc_pkg::LOW_CENTI))
              && (temp_full < 19'(ntc_pkg::HIGH_CENTI));
        if (!t_valid_reg)
        begin
            temp_out = '0;
        end
        else if (temp_full > 19'sd32767)
        begin
            temp_out = 16'sh7FFF;
        end
        else if (temp_full < -19'sd32768)
        begin
            temp_out = -16'sd32768;
        end
        else
        begin
            temp_out = temp_full[15:0];
        end
    end

    // configuration, batch and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg     <= 13'd3300;
            fixed_r_reg    <= 20'd10000;
            r0_reg         <= 20'd10000;
            beta_reg       <= 14'd3950;
            t0_reg         <= 15'd2500;
            count_reg      <= 9'd16;
            cal_active_reg <= 1'b1;
            idx_reg        <= '0;
            raw_tot_reg    <= '0;
            cal_tot_reg    <= '0;
            r_valid_reg    <= 1'b0;
            t_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ntc_pkg::REG_SUPPLY:  supply_reg     <= cfg_data[12:0];
                    ntc_pkg::REG_FIXED_R: fixed_r_reg    <= cfg_data;
                    ntc_pkg::REG_R0:      r0_reg         <= cfg_data;
                    ntc_pkg::REG_BETA:    beta_reg       <= cfg_data[13:0];
                    ntc_pkg::REG_T0:      t0_reg         <= cfg_data[14:0];
                    ntc_pkg::REG_COUNT:   count_reg      <= cfg_data[8:0];
                    ntc_pkg::REG_CAL_EN:  cal_active_reg <= cfg_data[0];
                    default:              count_reg      <= count_reg;
                endcase
            end
            case (cmd.op)
                ntc_pkg::OP_ACCEPT:
                begin
                    if (!read_ok)
                    begin
                        idx_reg     <= '0;
                        raw_tot_reg <= '0;
                        cal_tot_reg <= '0;
                    end
                    else
                    begin
                        raw_tot_reg <= raw_tot_reg + ntc_pkg::TOT_W'(raw_code);
                        idx_reg     <= idx_reg + 9'd1;
                        if (cal_active_reg)
                        begin
                            if (cal_ok)
                            begin
                                cal_tot_reg <= cal_tot_reg + ntc_pkg::TOT_W'(cal_mv);
                            end
                            else
                            begin
                                cal_active_reg <= 1'b0;
                            end
                        end
                    end
                end
                ntc_pkg::OP_VDIV:
                begin
                    idx_reg     <= '0;
                    raw_tot_reg <= '0;
                    cal_tot_reg <= '0;
                    t_valid_reg <= 1'b0;
                    r_valid_reg <= 1'b0;
                end
                ntc_pkg::OP_STV:
                begin
                    if (div_done)
                    begin
                        r_valid_reg <= (div_q[16:0] > 17'd16)
                                       && ({1'b0, div_q[16:0]} + 18'd16 < {1'b0, supply_q4});
                    end
                end
                ntc_pkg::OP_STT:
                begin
                    if (div_done)
                    begin
                        t_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    t_valid_reg <= t_valid_reg;
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != ntc_pkg::MUL_HOLD)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.op == ntc_pkg::OP_NLOAD)
        begin
            norm_x_reg <= norm_src;
            norm_e_reg <= 6'(ntc_pkg::RQ_W - 1);
        end
        else if (!norm_x_reg[ntc_pkg::RQ_W-1])
        begin
            norm_x_reg <= {norm_x_reg[ntc_pkg::RQ_W-2:0], 1'b0};
            norm_e_reg <= norm_e_reg - 6'd1;
        end
        case (cmd.op)
            ntc_pkg::OP_STV:
            begin
                if (div_done)
                begin
                    v_reg <= div_q[16:0];
                end
            end
            ntc_pkg::OP_STRQ:
            begin
                if (div_done)
                begin
                    rq_reg <= div_q[ntc_pkg::RQ_W-1:0];
                end
            end
            ntc_pkg::OP_LOOK:
            begin
                lo_reg   <= ntc_pkg::LOG_TABLE[tab_idx];
                dl_reg   <= ntc_pkg::LOG_TABLE[{1'b0, tab_idx} + 9'd1]
                            - ntc_pkg::LOG_TABLE[tab_idx];
                frac_reg <= norm_x_reg[35:12];
                e_reg    <= norm_e_reg;
            end
            ntc_pkg::OP_STLOG:
            begin
                if (cmd.second)
                begin
                    log0_reg <= log_val;
                end
                else
                begin
                    logr_reg <= log_val;
                end
            end
            ntc_pkg::OP_DIFF:
            begin
                diff_neg_reg <= diff_s[38];
                diff_mag_reg <= diff_s[38] ? 36'(-diff_s) : 36'(diff_s);
            end
            ntc_pkg::OP_SAVE:
            begin
                save_reg <= prod_reg[41:0];
            end
            ntc_pkg::OP_L24:
            begin
                l24_reg <= l24_sum[60:30];
            end
            ntc_pkg::OP_NUM:
            begin
                num_reg <= {prod_reg[37:0], 24'd0};
            end
            ntc_pkg::OP_B100:
            begin
                b100_reg <= prod_reg[20:0];
            end
            ntc_pkg::OP_DEN:
            begin
                if (!diff_neg_reg)
                begin
                    den_mag_reg <= b_sh + p_tl;
                    den_neg_reg <= 1'b0;
                end
                else if (p_tl > b_sh)
                begin
                    den_mag_reg <= p_tl - b_sh;
                    den_neg_reg <= 1'b1;
                end
                else
                begin
                    den_mag_reg <= b_sh - p_tl;
                    den_neg_reg <= 1'b0;
                end
                den_zero_reg <= diff_neg_reg && (p_tl == b_sh);
            end
            ntc_pkg::OP_STT:
            begin
                if (div_done)
                begin
                    q_reg <= (div_q[63:17] != '0) ? 17'h1FFFF : div_q[16:0];
                end
            end
            ntc_pkg::OP_OUT:
            begin
                voltage_q4_mv       <= v_reg[16] ? 16'hFFFF : v_reg[15:0];
                rtherm_ohm          <= r_out;
                temperature_centi_c <= temp_out;
                in_range            <= inr;
                status              <= inr ? ntc_pkg::STAT_OK : ntc_pkg::STAT_INVALID;
            end
            ntc_pkg::OP_OUTFAIL:
            begin
                voltage_q4_mv       <= '0;
                rtherm_ohm          <= '0;
                temperature_centi_c <= '0;
                in_range            <= 1'b0;
                status              <= ntc_pkg::STAT_FAIL;
            end
            default:
            begin
                e_reg <= e_reg;
            end
        endcase
    end

    `NTC_ASSERT(a_div_free, div_start |-> !div_busy)
    `NTC_ASSERT(a_norm_src, (cmd.op == ntc_pkg::OP_NLOAD) |-> (norm_src != '0))
    `NTC_ASSERT_NEXT(a_batch_clear, cmd.op == ntc_pkg::OP_VDIV, (idx_reg == '0) && !t_valid_reg)

endmodule

>>> rtl/ntc_ctrl.sv
// Sequencer: accepts samples, steps the datapath through a closing reading, owns the output valid.
`include "ntc_thermistor_temperature_macros.svh"

module ntc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    input  ntc_pkg::stat_t  st,
    output ntc_pkg::cmd_t   cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_FAIL  = 5'd1;
    localparam logic [4:0] S_MULV  = 5'd2;
    localparam logic [4:0] S_VDIV  = 5'd3;
    localparam logic [4:0] S_VWAIT = 5'd4;
    localparam logic [4:0] S_MULR  = 5'd5;
    localparam logic [4:0] S_RDIV  = 5'd6;
    localparam logic [4:0] S_RWAIT = 5'd7;
    localparam logic [4:0] S_CHK   = 5'd8;
    localparam logic [4:0] S_NLOAD = 5'd9;
    localparam logic [4:0] S_NORM  = 5'd10;
    localparam logic [4:0] S_LOOK  = 5'd11;
    localparam logic [4:0] S_MULI  = 5'd12;
    localparam logic [4:0] S_LOG   = 5'd13;
    localparam logic [4:0] S_DIFF  = 5'd14;
    localparam logic [4:0] S_MD0   = 5'd15;
    localparam logic [4:0] S_MD1   = 5'd16;
    localparam logic [4:0] S_L24   = 5'd17;
    localparam logic [4:0] S_MT    = 5'd18;
    localparam logic [4:0] S_MN    = 5'd19;
    localparam logic [4:0] S_MB    = 5'd20;
    localparam logic [4:0] S_ML    = 5'd21;
    localparam logic [4:0] S_DEN   = 5'd22;
    localparam logic [4:0] S_DCHK  = 5'd23;
    localparam logic [4:0] S_TDIV  = 5'd24;
    localparam logic [4:0] S_TWAIT = 5'd25;
    localparam logic [4:0] S_EMIT  = 5'd26;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       second_reg;
    logic       second_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        cmd.op      = ntc_pkg::OP_NONE;
        cmd.mul_sel = ntc_pkg::MUL_HOLD;
        cmd.second  = second_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.op = ntc_pkg::OP_ACCEPT;
                    if (st.in_fail)
                    begin
                        state_next = S_FAIL;
                    end
                    else if (st.closing)
                    begin
                        state_next = S_MULV;
                    end
                end
            end
            S_FAIL:
            begin
                if (out_free)
                begin
                    cmd.op     = ntc_pkg::OP_OUTFAIL;
                    state_next = S_IDLE;
                end
            end
            S_MULV:
            begin
                cmd.mul_sel = ntc_pkg::MUL_RAW;
                state_next  = S_VDIV;
            end
            S_VDIV:
            begin
                cmd.op     = ntc_pkg::OP_VDIV;
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                cmd.op = ntc_pkg::OP_STV;
                if (st.div_done)
                begin
                    state_next = S_MULR;
                end
            end
            S_MULR:
            begin
                cmd.mul_sel = ntc_pkg::MUL_RV;
                state_next  = st.r_valid ? S_RDIV : S_EMIT;
            end
            S_RDIV:
            begin
                cmd.op     = ntc_pkg::OP_RDIV;
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                cmd.op = ntc_pkg::OP_STRQ;
                if (st.div_done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                second_next = 1'b0;
                state_next  = st.t_ok ? S_NLOAD : S_EMIT;
            end
            S_NLOAD:
            begin
                cmd.op     = ntc_pkg::OP_NLOAD;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (st.norm_done)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.op     = ntc_pkg::OP_LOOK;
                state_next = S_MULI;
            end
            S_MULI:
            begin
                cmd.mul_sel = ntc_pkg::MUL_INT;
                state_next  = S_LOG;
            end
            S_LOG:
            begin
                cmd.op = ntc_pkg::OP_STLOG;
                if (second_reg)
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    second_next = 1'b1;
                    state_next  = S_NLOAD;
                end
            end
            S_DIFF:
            begin
                cmd.op     = ntc_pkg::OP_DIFF;
                state_next = S_MD0;
            end
            S_MD0:
            begin
                cmd.mul_sel = ntc_pkg::MUL_D0;
                state_next  = S_MD1;
            end
            S_MD1:
            begin
                cmd.mul_sel = ntc_pkg::MUL_D1;
                cmd.op      = ntc_pkg::OP_SAVE;
                state_next  = S_L24;
            end
            S_L24:
            begin
                cmd.op     = ntc_pkg::OP_L24;
                state_next = S_MT;
            end
            S_MT:
            begin
                cmd.mul_sel = ntc_pkg::MUL_TB;
                state_next  = S_MN;
            end
            S_MN:
            begin
                cmd.mul_sel = ntc_pkg::MUL_TB100;
                state_next  = S_MB;
            end
            S_MB:
            begin
                cmd.mul_sel = ntc_pkg::MUL_B100;
                cmd.op      = ntc_pkg::OP_NUM;
                state_next  = S_ML;
            end
            S_ML:
            begin
                cmd.mul_sel = ntc_pkg::MUL_TL;
                cmd.op      = ntc_pkg::OP_B100;
                state_next  = S_DEN;
            end
            S_DEN:
            begin
                cmd.op     = ntc_pkg::OP_DEN;
                state_next = S_DCHK;
            end
            S_DCHK:
            begin
                state_next = st.den_zero ? S_EMIT : S_TDIV;
            end
            S_TDIV:
            begin
                cmd.op     = ntc_pkg::OP_TDIV;
                state_next = S_TWAIT;
            end
            S_TWAIT:
            begin
                cmd.op = ntc_pkg::OP_STT;
                if (st.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.op     = ntc_pkg::OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (cmd.op == ntc_pkg::OP_OUT || cmd.op == ntc_pkg::OP_OUTFAIL)
        begin
            m_tvalid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            second_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            second_reg   <= second_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `NTC_ASSERT(a_out_free, (cmd.op == ntc_pkg::OP_OUT || cmd.op == ntc_pkg::OP_OUTFAIL) |-> out_free)
    `NTC_ASSERT_NEXT(a_close_busy, s_tvalid && s_tready && st.closing, state_reg != S_IDLE)
    `NTC_ASSERT(a_both_logs, (state_reg == S_TDIV) |-> second_reg)

endmodule

>>> rtl/ntc_thermistor_temperature.sv
// NTC thermistor thermometer: sample averaging, divider resistance and Beta-equation temperature.
//
// Input words carry one converter sample: tdata = raw_code, cal_mv; tuser = cal_ok, read_ok.
// A sample that does not complete a batch is taken without leaving idle and gives no result.
// The sample that completes a batch of sample_count samples (0 acts as 1, above 256 as 256)
// starts the reading; the block holds s_tready low until the result word is loaded, which
// includes any wait for the output register to drain. The wait is set by up to three
// 64-step passes of the shared one-bit-per-cycle divider (voltage average, resistance,
// temperature) and by the one-bit normaliser ahead of each table log; the later steps are
// skipped when the voltage is out of band or the resistance, R0 or Beta is zero.
// A sample with read_ok low aborts the batch; its status 1 word waits for a free output register.
// Results sit in an output register; the next batch's samples are still taken while it
// waits, and a new result waits for the register to drain when m_tready is held low.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user writes it only while
// the block is idle, which it does not enforce; writing 1 to cal_enable re-arms calibration.
// Reset loads the default register values, empties the batch and arms calibration.
module ntc_thermistor_temperature (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // raw_code[11:0], cal_mv[23:12]
    input  logic [1:0]  s_tuser,   // cal_ok[0], read_ok[1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // voltage_q4_mv[15:0], rtherm_ohm[39:16],
                                   // temperature_centi_c[55:40]
    output logic [2:0]  m_tuser,   // in_range[0], status[2:1]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    ntc_pkg::cmd_t      cmd;
    ntc_pkg::stat_t     st;
    logic [15:0]        voltage_q4_mv;
    logic [23:0]        rtherm_ohm;
    logic signed [15:0] temperature_centi_c;
    logic               in_range;
    logic [1:0]         status;

    ntc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    ntc_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .st                  (st),
        .raw_code            (s_tdata[11:0]),
        .cal_mv              (s_tdata[23:12]),
        .cal_ok              (s_tuser[0]),
        .read_ok             (s_tuser[1]),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .voltage_q4_mv       (voltage_q4_mv),
        .rtherm_ohm          (rtherm_ohm),
        .temperature_centi_c (temperature_centi_c),
        .in_range            (in_range),
        .status              (status)
    );

    assign m_tdata = {temperature_centi_c, rtherm_ohm, voltage_q4_mv};
    assign m_tuser = {status, in_range};

endmodule
